// File: design/assert_macros.svh
// assertion macros used by the sort engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/qse_pkg.sv
// types shared by the sort engine modules
`timescale 1ns / 1ps
package qse_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } qse_state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } qse_ctrl_t;

endpackage

// File: design/qse_if.sv
// handshake channel interfaces for input and result words
`timescale 1ns / 1ps
interface qse_in_if;
  import qse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface qse_out_if;
  import qse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] sorted_value;
  logic                    final_res;
  logic                    overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface

// File: design/quicksort_engine.sv
// Sorting engine: collects a set of signed 32-bit words and returns them in
// ascending order. While loading, one word is taken every cycle; each word is
// placed at its sorted position in a chain of DEPTH cells in the cycle it
// arrives, so no sort phase follows the last word. The cycle after the word
// flagged last, the set drains from the head of the chain, one result word per
// cycle that the sink takes, and no input is taken until the final result is
// gone. Words beyond DEPTH are dropped and every result of that set carries
// overflow.
`timescale 1ns / 1ps
module quicksort_engine
  import qse_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qse_in_if.sink     in_i,
  qse_out_if.source  out_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  qse_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  qse_ctrl_t ctrl;

  logic                    take [DEPTH];
  logic signed [DataW-1:0] held [DEPTH];

  logic in_fire, out_fire, full;

  assign full     = (count_q == CntW'(DEPTH));
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CntW'(1);
          end
          if (in_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        out_o.valid = 1'b1;
        if (out_fire) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_take;
    logic signed [DataW-1:0] left_value;
    logic signed [DataW-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = '0;
    end else begin : g_body
      assign left_take  = take[i-1];
      assign left_value = held[i-1];
    end

    // the tail cell refills with its own word while draining
    if (i == DEPTH - 1) begin : g_tail
      assign right_value = held[i];
    end else begin : g_mid
      assign right_value = held[i+1];
    end

    qse_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CntW'(i) < count_q),
      .new_value_i  (in_i.value),
      .left_take_i  (left_take),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .take_o       (take[i]),
      .value_o      (held[i])
    );
  end

  assign out_o.sorted_value = held[0];
  assign out_o.final_res    = (count_q == CntW'(1));
  assign out_o.overflow     = ovf_q;

  `ASSERT_CLK(a_drain_nonempty, clk_i, rst_ni, out_o.valid |-> (count_q != '0),
              "result offered from an empty chain")
  `ASSERT_CLK(a_no_load_in_drain, clk_i, rst_ni, (state_q == ST_DRAIN) |-> !in_i.ready,
              "input taken while draining")
  `ASSERT_CLK(a_final_ends_set, clk_i, rst_ni,
              (out_fire && out_o.final_res) |=> (state_q == ST_LOAD && count_q == '0 && !ovf_q),
              "set not closed after final result")
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH),
              "element count beyond capacity")

endmodule

// File: design/qse_cell.sv
// one cell of the insertion chain: holds one element in sorted position
`timescale 1ns / 1ps
module qse_cell
  import qse_pkg::*;
(
  input  logic                    clk_i,
  input  qse_ctrl_t               ctrl_i,
  input  logic                    occupied_i,
  input  logic signed [DataW-1:0] new_value_i,
  input  logic                    left_take_i,
  input  logic signed [DataW-1:0] left_value_i,
  input  logic signed [DataW-1:0] right_value_i,
  output logic                    take_o,
  output logic signed [DataW-1:0] value_o
);

  logic signed [DataW-1:0] held_q, held_d;

  // new word belongs at or before this slot
  assign take_o  = !occupied_i || (new_value_i < held_q);
  assign value_o = held_q;

  always_comb begin
    held_d = held_q;
    if (ctrl_i.insert && take_o) begin
      // if the left neighbor also moves, its word shifts in here
      held_d = left_take_i ? left_value_i : new_value_i;
    end else if (ctrl_i.shift) begin
      held_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule
